/* design/rmtb_pkg.sv */
// Shared constants for the residue to binary converter: field widths,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package rmtb_pkg;

  localparam int DATA_W      = 16;
  localparam int VALUE_W     = 64;
  localparam int IN_TDATA_W  = 4 * DATA_W;
  localparam int OUT_TDATA_W = VALUE_W + 4 * DATA_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int INV_HIGH_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] IDX_MODULUS_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] IDX_MODULUS_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] IDX_MODULUS_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] IDX_MODULUS_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] IDX_INV_LOW   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] IDX_INV_HIGH  = 3'd5;

  localparam logic [DATA_W-1:0]     RST_MODULUS_0 = 16'd7;
  localparam logic [DATA_W-1:0]     RST_MODULUS_1 = 16'd8;
  localparam logic [DATA_W-1:0]     RST_MODULUS_2 = 16'd9;
  localparam logic [DATA_W-1:0]     RST_MODULUS_3 = 16'd11;
  localparam logic [CFG_DATA_W-1:0] RST_INV_LOW   = 64'd2251834173685767;
  localparam logic [INV_HIGH_W-1:0] RST_INV_HIGH  = 32'd327687;

endpackage

/* design/rmtb_modred.sv */
// Pipelined restoring modular reduction, eight quotient bits per stage,
// several independent lanes in parallel. Depends on nothing.
`timescale 1ns / 1ps

module rmtb_modred #(
  parameter int XW = 16,
  parameter int N  = 1,
  parameter int MW = 16,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [XW-1:0] x [N],
  input  logic [MW-1:0] m [N],
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [MW-1:0] r [N],
  output logic [PW-1:0] out_pay
);

  localparam int SPS = 8;
  localparam int NS  = (XW + SPS - 1) / SPS;
  localparam int XP  = NS * SPS;

  logic [XP-1:0] xs  [NS][N];
  logic [MW:0]   rs  [NS][N];
  logic          v   [NS];
  logic [PW-1:0] pay [NS];

  logic [XP-1:0] xin [NS][N];
  logic [MW:0]   rin [NS][N];
  logic          vin [NS];
  logic [PW-1:0] pin [NS];

  function automatic logic [MW:0] steps(logic [MW:0] r0, logic [SPS-1:0] bits,
                                        logic [MW-1:0] mod);
    logic [MW:0] acc;
    acc = r0;
    for (int k = SPS - 1; k >= 0; k--) begin
      acc = {acc[MW-1:0], bits[k]};
      if (acc >= {1'b0, mod}) acc = acc - {1'b0, mod};
    end
    return acc;
  endfunction

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        vin[s] = in_valid;
        pin[s] = in_pay;
        for (int i = 0; i < N; i++) begin
          xin[s][i] = XP'(x[i]);
          rin[s][i] = '0;
        end
      end else begin
        vin[s] = v[s-1];
        pin[s] = pay[s-1];
        for (int i = 0; i < N; i++) begin
          xin[s][i] = xs[s-1][i];
          rin[s][i] = rs[s-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (ce) begin
        v[s] <= vin[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int s = 0; s < NS; s++) begin
        pay[s] <= pin[s];
        for (int i = 0; i < N; i++) begin
          xs[s][i] <= xin[s][i];
          rs[s][i] <= steps(rin[s][i], xin[s][i][XP-1-s*SPS -: SPS], m[i]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      r[i] = (m[i] == '0) ? '0 : rs[NS-1][i][MW-1:0];
    end
  end

  assign out_valid = v[NS-1];
  assign out_pay   = pay[NS-1];

endmodule

/* design/rmtb_step.sv */
// One mixed-radix step per lane: ((acc - digit) * inv) mod m, reduced first.
// Depends on rmtb_modred.
`timescale 1ns / 1ps

module rmtb_step #(
  parameter int MW = 16,
  parameter int N  = 1,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [MW-1:0] acc   [N],
  input  logic [MW-1:0] digit [N],
  input  logic [MW-1:0] inv   [N],
  input  logic [MW-1:0] m     [N],
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [MW-1:0] res   [N],
  output logic [PW-1:0] out_pay
);

  logic [MW-1:0]   rx   [3*N];
  logic [MW-1:0]   rm   [3*N];
  logic [MW-1:0]   rr   [3*N];
  logic            red_valid;
  logic [PW-1:0]   red_pay;

  logic [MW-1:0]   t_r    [N];
  logic [MW-1:0]   inv_r  [N];
  logic            sub_valid;
  logic [PW-1:0]   sub_pay;

  logic [2*MW-1:0] prod_r [N];
  logic            mul_valid;
  logic [PW-1:0]   mul_pay;

  logic [MW:0]     t_full [N];
  logic [MW-1:0]   t_sel  [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rx[3*i]     = acc[i];
      rx[3*i + 1] = digit[i];
      rx[3*i + 2] = inv[i];
      rm[3*i]     = m[i];
      rm[3*i + 1] = m[i];
      rm[3*i + 2] = m[i];
    end
  end

  rmtb_modred #(.XW(MW), .N(3*N), .MW(MW), .PW(PW)) u_red_in (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(in_valid), .x(rx), .m(rm), .in_pay(in_pay),
    .out_valid(red_valid), .r(rr), .out_pay(red_pay)
  );

  always_comb begin
    for (int i = 0; i < N; i++) begin
      t_full[i] = {1'b0, rr[3*i]} + {1'b0, m[i]} - {1'b0, rr[3*i + 1]};
      if (t_full[i] >= {1'b0, m[i]}) begin
        t_sel[i] = MW'(t_full[i] - {1'b0, m[i]});
      end else begin
        t_sel[i] = t_full[i][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_valid <= 1'b0;
      mul_valid <= 1'b0;
    end else if (ce) begin
      sub_valid <= red_valid;
      mul_valid <= sub_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sub_pay <= red_pay;
      mul_pay <= sub_pay;
      for (int i = 0; i < N; i++) begin
        t_r[i]    <= t_sel[i];
        inv_r[i]  <= rr[3*i + 2];
        prod_r[i] <= t_r[i] * inv_r[i];
      end
    end
  end

  rmtb_modred #(.XW(2*MW), .N(N), .MW(MW), .PW(PW)) u_red_prod (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(mul_valid), .x(prod_r), .m(m), .in_pay(mul_pay),
    .out_valid(out_valid), .r(res), .out_pay(out_pay)
  );

endmodule

/* design/rns_mixed_radix_to_binary.sv */
// Top level: four-channel residue to binary converter by mixed-radix conversion.
// Depends on rmtb_pkg, rmtb_step and rmtb_modred.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one residue vector per transfer, m_axis returns the value
//   and the four mixed-radix digits. cfg_we/cfg_index/cfg_data write the
//   moduli and the packed inverses; write them only while no item is in flight.
//   Throughput: one transfer per cycle while the output is not stalled. Each
//   step is a pipelined restoring reduction of its operands, a subtract
//   register, a multiply register and a pipelined restoring reduction of the
//   product (eight bits per stage; the product reduction is twice as wide).
//   The three step levels follow the dependence d1 -> d2 -> d3; the value is
//   formed in three stages (products, partial sums, final add).
//   Reset loads the default moduli and inverses and empties the pipeline.
//   When m_axis_tready is low with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.

module rns_mixed_radix_to_binary #(
  parameter int MODULUS_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // residue_0, residue_1, residue_2, residue_3
  input  logic [rmtb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // value, digit_0, digit_1, digit_2, digit_3
  output logic [rmtb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [rmtb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rmtb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MW = MODULUS_WIDTH;
  localparam int DW = rmtb_pkg::DATA_W;
  localparam int VW = rmtb_pkg::VALUE_W;

  logic [DW-1:0]                     modulus_0, modulus_1, modulus_2, modulus_3;
  logic [rmtb_pkg::CFG_DATA_W-1:0]   inverse_pack_low;
  logic [rmtb_pkg::INV_HIGH_W-1:0]   inverse_pack_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_0         <= rmtb_pkg::RST_MODULUS_0;
      modulus_1         <= rmtb_pkg::RST_MODULUS_1;
      modulus_2         <= rmtb_pkg::RST_MODULUS_2;
      modulus_3         <= rmtb_pkg::RST_MODULUS_3;
      inverse_pack_low  <= rmtb_pkg::RST_INV_LOW;
      inverse_pack_high <= rmtb_pkg::RST_INV_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        rmtb_pkg::IDX_MODULUS_0: modulus_0 <= cfg_data[DW-1:0];
        rmtb_pkg::IDX_MODULUS_1: modulus_1 <= cfg_data[DW-1:0];
        rmtb_pkg::IDX_MODULUS_2: modulus_2 <= cfg_data[DW-1:0];
        rmtb_pkg::IDX_MODULUS_3: modulus_3 <= cfg_data[DW-1:0];
        rmtb_pkg::IDX_INV_LOW:   inverse_pack_low <= cfg_data;
        rmtb_pkg::IDX_INV_HIGH:  inverse_pack_high <= cfg_data[rmtb_pkg::INV_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [MW-1:0] m0, m1, m2, m3;
  logic [MW-1:0] i01, i02, i03, i12, i13, i23;

  assign m0  = modulus_0[MW-1:0];
  assign m1  = modulus_1[MW-1:0];
  assign m2  = modulus_2[MW-1:0];
  assign m3  = modulus_3[MW-1:0];
  assign i01 = inverse_pack_low[MW-1:0];
  assign i02 = inverse_pack_low[DW +: MW];
  assign i03 = inverse_pack_low[2*DW +: MW];
  assign i12 = inverse_pack_low[3*DW +: MW];
  assign i13 = inverse_pack_high[MW-1:0];
  assign i23 = inverse_pack_high[DW +: MW];

  // weights follow the moduli after a write: w2 = m0 * m1 and w3 = w2 * m2, each registered
  logic [2*MW-1:0] w2;
  logic [3*MW-1:0] w3;

  always_ff @(posedge clk) begin
    w2 <= m0 * m1;
    w3 <= w2 * m2;
  end

  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  logic [MW-1:0] d0_in;
  assign d0_in = s_axis_tdata[MW-1:0];

  // level 1: d1, and the first step of channels 2 and 3
  logic [MW-1:0] l1_acc [3], l1_dig [3], l1_inv [3], l1_m [3], l1_res [3];
  logic          l1_valid;
  logic [MW-1:0] l1_pay;

  assign l1_acc = '{s_axis_tdata[DW +: MW], s_axis_tdata[2*DW +: MW],
                    s_axis_tdata[3*DW +: MW]};
  assign l1_dig = '{d0_in, d0_in, d0_in};
  assign l1_inv = '{i01, i02, i03};
  assign l1_m   = '{m1, m2, m3};

  rmtb_step #(.MW(MW), .N(3), .PW(MW)) u_level1 (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(s_axis_tvalid && s_axis_tready),
    .acc(l1_acc), .digit(l1_dig), .inv(l1_inv), .m(l1_m), .in_pay(d0_in),
    .out_valid(l1_valid), .res(l1_res), .out_pay(l1_pay)
  );

  // level 2: d2, and the second step of channel 3
  logic [MW-1:0]   l2_acc [2], l2_dig [2], l2_inv [2], l2_m [2], l2_res [2];
  logic            l2_valid;
  logic [2*MW-1:0] l2_pay;

  assign l2_acc = '{l1_res[1], l1_res[2]};
  assign l2_dig = '{l1_res[0], l1_res[0]};
  assign l2_inv = '{i12, i13};
  assign l2_m   = '{m2, m3};

  rmtb_step #(.MW(MW), .N(2), .PW(2*MW)) u_level2 (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(l1_valid),
    .acc(l2_acc), .digit(l2_dig), .inv(l2_inv), .m(l2_m),
    .in_pay({l1_res[0], l1_pay}),
    .out_valid(l2_valid), .res(l2_res), .out_pay(l2_pay)
  );

  // level 3: d3
  logic [MW-1:0]   l3_acc [1], l3_dig [1], l3_inv [1], l3_m [1], l3_res [1];
  logic            l3_valid;
  logic [3*MW-1:0] l3_pay;

  assign l3_acc = '{l2_res[1]};
  assign l3_dig = '{l2_res[0]};
  assign l3_inv = '{i23};
  assign l3_m   = '{m3};

  rmtb_step #(.MW(MW), .N(1), .PW(3*MW)) u_level3 (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(l2_valid),
    .acc(l3_acc), .digit(l3_dig), .inv(l3_inv), .m(l3_m),
    .in_pay({l2_res[0], l2_pay}),
    .out_valid(l3_valid), .res(l3_res), .out_pay(l3_pay)
  );

  // value: products, partial sums, final add (output register)
  logic            v1_valid, v2_valid;
  logic [MW-1:0]   v1_d0, v1_d1, v1_d2, v1_d3;
  logic [MW-1:0]   v2_d0, v2_d1, v2_d2, v2_d3;
  logic [2*MW-1:0] p1, p3hi;
  logic [3*MW-1:0] p2, p3lo;
  logic [VW-1:0]   s1, s2;
  logic [VW-1:0]   value;
  logic [MW-1:0]   o_d0, o_d1, o_d2, o_d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_valid      <= 1'b0;
      v2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      v1_valid      <= l3_valid;
      v2_valid      <= v1_valid;
      m_axis_tvalid <= v2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      v1_d0 <= l3_pay[MW-1:0];
      v1_d1 <= l3_pay[MW +: MW];
      v1_d2 <= l3_pay[2*MW +: MW];
      v1_d3 <= l3_res[0];
      p1    <= m0 * l3_pay[MW +: MW];
      p2    <= w2 * l3_pay[2*MW +: MW];
      p3lo  <= w3[2*MW-1:0] * l3_res[0];
      p3hi  <= w3[3*MW-1:2*MW] * l3_res[0];

      v2_d0 <= v1_d0;
      v2_d1 <= v1_d1;
      v2_d2 <= v1_d2;
      v2_d3 <= v1_d3;
      s1    <= VW'(v1_d0) + VW'(p1) + VW'(p2);
      s2    <= VW'(p3lo) + (VW'(p3hi) << (2*MW));

      o_d0  <= v2_d0;
      o_d1  <= v2_d1;
      o_d2  <= v2_d2;
      o_d3  <= v2_d3;
      value <= s1 + s2;
    end
  end

  assign m_axis_tdata = {DW'(o_d3), DW'(o_d2), DW'(o_d1), DW'(o_d0), value};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_cfg_inv_high: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == rmtb_pkg::IDX_INV_HIGH)
      |=> inverse_pack_high == $past(cfg_data[rmtb_pkg::INV_HIGH_W-1:0]))
    else $error("inverse_pack_high write lost");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

endmodule

/* tb/sv/rmtb_checker.sv */
// Checker for the residue to binary converter: mirrors the configuration
// writes, predicts value and digits per input transfer, compares outputs.
// Depends on rmtb_pkg.
`timescale 1ns / 1ps

module rmtb_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [rmtb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [rmtb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [rmtb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rmtb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic [rmtb_pkg::DATA_W-1:0]  digit_3;
    logic [rmtb_pkg::DATA_W-1:0]  digit_2;
    logic [rmtb_pkg::DATA_W-1:0]  digit_1;
    logic [rmtb_pkg::DATA_W-1:0]  digit_0;
    logic [rmtb_pkg::VALUE_W-1:0] value;
  } conv_result_t;

  logic [rmtb_pkg::DATA_W-1:0]     mod_q [4];
  logic [rmtb_pkg::CFG_DATA_W-1:0] inv_low_q;
  logic [rmtb_pkg::INV_HIGH_W-1:0] inv_high_q;
  conv_result_t                    expected_conv [$];

  assign pending = expected_conv.size();

  function automatic logic [63:0] mrc_step(logic [63:0] acc, logic [63:0] dig,
                                           logic [63:0] inv, logic [63:0] m);
    logic [63:0] t;
    if (m == '0) return '0;
    t = (acc % m + m - dig % m) % m;
    return (t * (inv % m)) % m;
  endfunction

  function automatic conv_result_t convert(logic [rmtb_pkg::IN_TDATA_W-1:0] d);
    logic [63:0] m [4];
    logic [63:0] r [4];
    logic [63:0] acc, d1, d2, d3, w, v;
    conv_result_t res;
    for (int i = 0; i < 4; i++) begin
      m[i] = 64'(mod_q[i]);
      r[i] = 64'(d[i*rmtb_pkg::DATA_W +: rmtb_pkg::DATA_W]);
    end
    d1  = mrc_step(r[1], r[0], 64'(inv_low_q[15:0]), m[1]);
    acc = mrc_step(r[2], r[0], 64'(inv_low_q[31:16]), m[2]);
    d2  = mrc_step(acc, d1, 64'(inv_low_q[63:48]), m[2]);
    acc = mrc_step(r[3], r[0], 64'(inv_low_q[47:32]), m[3]);
    acc = mrc_step(acc, d1, 64'(inv_high_q[15:0]), m[3]);
    d3  = mrc_step(acc, d2, 64'(inv_high_q[31:16]), m[3]);
    w = m[0];
    v = r[0] + w * d1;
    w = w * m[1];
    v = v + w * d2;
    w = w * m[2];
    v = v + w * d3;
    res.value   = v;
    res.digit_0 = r[0][rmtb_pkg::DATA_W-1:0];
    res.digit_1 = d1[rmtb_pkg::DATA_W-1:0];
    res.digit_2 = d2[rmtb_pkg::DATA_W-1:0];
    res.digit_3 = d3[rmtb_pkg::DATA_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    conv_result_t got, exp_r;
    if (rst) begin
      mod_q[0] <= rmtb_pkg::RST_MODULUS_0;
      mod_q[1] <= rmtb_pkg::RST_MODULUS_1;
      mod_q[2] <= rmtb_pkg::RST_MODULUS_2;
      mod_q[3] <= rmtb_pkg::RST_MODULUS_3;
      inv_low_q  <= rmtb_pkg::RST_INV_LOW;
      inv_high_q <= rmtb_pkg::RST_INV_HIGH;
      expected_conv.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rmtb_pkg::IDX_MODULUS_0: mod_q[0] <= cfg_data[rmtb_pkg::DATA_W-1:0];
          rmtb_pkg::IDX_MODULUS_1: mod_q[1] <= cfg_data[rmtb_pkg::DATA_W-1:0];
          rmtb_pkg::IDX_MODULUS_2: mod_q[2] <= cfg_data[rmtb_pkg::DATA_W-1:0];
          rmtb_pkg::IDX_MODULUS_3: mod_q[3] <= cfg_data[rmtb_pkg::DATA_W-1:0];
          rmtb_pkg::IDX_INV_LOW:   inv_low_q <= cfg_data;
          rmtb_pkg::IDX_INV_HIGH:  inv_high_q <= cfg_data[rmtb_pkg::INV_HIGH_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_conv.push_back(convert(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_conv.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected transfer: %h", got);
        end else begin
          exp_r = expected_conv.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: value %h/%h d0 %h/%h d1 %h/%h d2 %h/%h d3 %h/%h (exp/got)",
                       exp_r.value, got.value, exp_r.digit_0, got.digit_0,
                       exp_r.digit_1, got.digit_1, exp_r.digit_2, got.digit_2,
                       exp_r.digit_3, got.digit_3);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_rns_mixed_radix_to_binary.sv */
// Testbench top for rns_mixed_radix_to_binary: drives configuration, residue
// stimulus and output stalls; verdict from rmtb_checker. Depends on all others.
`timescale 1ns / 1ps

module tb_rns_mixed_radix_to_binary;

  localparam int LATENCY = 27;
  localparam int LIMIT   = 200000;

  // indexes with no register behind them
  localparam logic [rmtb_pkg::CFG_INDEX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [rmtb_pkg::CFG_INDEX_W-1:0] IDX_SPARE_7 = 3'd7;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [rmtb_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [rmtb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [rmtb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rmtb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending, cycles = 0;
  bit calm = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  rns_mixed_radix_to_binary dut (.*);

  rmtb_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output stall bursts
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [rmtb_pkg::CFG_INDEX_W-1:0] idx,
                           logic [rmtb_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_residues(logic [15:0] r0, logic [15:0] r1,
                               logic [15:0] r2, logic [15:0] r3);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {r3, r2, r1, r0};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic stop_send();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  // residues mostly below the moduli, sometimes any 16-bit value
  function automatic logic [15:0] pick(logic [15:0] m);
    if (m == 0 || $urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, m - 1));
  endfunction

  task automatic random_phase(int count, logic [15:0] m [4]);
    for (int i = 0; i < count; i++)
      send_residues(pick(m[0]), pick(m[1]), pick(m[2]), pick(m[3]));
    stop_send();
  endtask

  initial begin
    logic [15:0] m [4];
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default base 7,8,9,11
    m = '{7, 8, 9, 11};
    send_residues(0, 0, 0, 0);
    send_residues(6, 7, 8, 10);
    send_residues(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_residues(3, 5, 2, 9);
    send_residues(7, 8, 9, 11);
    send_residues(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    stop_send();
    drain();

    // largest coprime moduli with arbitrary inverses, not the true ones
    write_reg(rmtb_pkg::IDX_MODULUS_0, 64'd65535);
    write_reg(rmtb_pkg::IDX_MODULUS_1, 64'd65521);
    write_reg(rmtb_pkg::IDX_MODULUS_2, 64'd65519);
    write_reg(rmtb_pkg::IDX_MODULUS_3, 64'd65497);
    write_reg(rmtb_pkg::IDX_INV_LOW, 64'hFFFF_1234_FFFF_0001);
    write_reg(rmtb_pkg::IDX_INV_HIGH, 64'h0000_0000_ABCD_FFFF);
    m = '{65535, 65521, 65519, 65497};
    send_residues(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_residues(0, 65520, 65518, 65496);
    send_residues(1, 2, 3, 4);
    stop_send();
    random_phase(150, m);
    drain();

    // zero and one moduli, wrapping high bits on config data
    write_reg(rmtb_pkg::IDX_MODULUS_0, 64'hFFFF_0000_0000_0000);
    write_reg(rmtb_pkg::IDX_MODULUS_1, 64'd1);
    write_reg(rmtb_pkg::IDX_MODULUS_2, 64'd0);
    write_reg(rmtb_pkg::IDX_MODULUS_3, 64'hABCD_0002);
    write_reg(rmtb_pkg::IDX_INV_LOW, 64'd0);
    write_reg(rmtb_pkg::IDX_INV_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    m = '{0, 1, 0, 2};
    send_residues(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_residues(0, 0, 0, 1);
    stop_send();
    drain();
    write_reg(IDX_SPARE_6, 64'd5);
    write_reg(IDX_SPARE_7, 64'd5);

    // random bases, small on even passes and up to 65535 on odd ones, with random inverses
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 4; k++) m[k] = 16'($urandom_range(2, p[0] ? 65535 : 300));
      for (int k = 0; k < 4; k++)
        write_reg(k[rmtb_pkg::CFG_INDEX_W-1:0], {$urandom, $urandom});
      for (int k = 0; k < 4; k++)
        write_reg(k[rmtb_pkg::CFG_INDEX_W-1:0], rmtb_pkg::CFG_DATA_W'(m[k]));
      write_reg(rmtb_pkg::IDX_INV_LOW, {$urandom, $urandom});
      write_reg(rmtb_pkg::IDX_INV_HIGH, {$urandom, $urandom});
      if (p == 3) calm = 1;
      random_phase(80, m);
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
design/rmtb_pkg.sv
design/rmtb_modred.sv
design/rmtb_step.sv
design/rns_mixed_radix_to_binary.sv
tb/sv/rmtb_checker.sv
tb/sv/tb_rns_mixed_radix_to_binary.sv
